// File: hdl/chd_pkg.sv
// Package for the chunked body decoder: phase and status codes, result types, byte helpers.
`default_nettype none
package chd_pkg;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [1:0] SKIP_LEN = 2'd2;
  localparam int unsigned HEX_BITS = 4;
  localparam int unsigned LEN_OUT_W = 32;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_DATA,
    PH_SKIP,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_BYTE     = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic                 ok;
    logic [HEX_BITS-1:0]  val;
  } hex_t;

  typedef struct packed {
    logic [7:0]           data;
    status_e              status;
    logic [LEN_OUT_W-1:0] length;
    logic                 last;
  } result_t;

  // Up to two results per accepted beat, in delivery order.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = '0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.val = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// File: hdl/chd_ifs.sv
// Valid/ready channel interfaces for raw body bytes in and decoded results out.
`default_nettype none
interface chd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink (input valid, input in_byte, input in_end, output ready);
endinterface

interface chd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  out_status;
  logic [31:0] body_length;
  logic        out_last;

  modport source (output valid, output out_byte, output out_status, output body_length,
                  output out_last, input ready);
  modport sink (input valid, input out_byte, input out_status, input body_length,
                input out_last, output ready);
endinterface
`default_nettype wire

// File: hdl/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked body decoder.
// A result beat enters the result queue when its input beat is accepted.
// Throughput: one input byte per cycle while the result queue has room; a byte that yields
// two beats (last payload byte plus truncated) pushes both into the four-entry result queue.
// Reset (rst_ni low, asynchronous) returns the parser to the size line and empties the queue.
`default_nettype none
module http_chunked_body_decoder #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  chd_in_if.sink     in_i,
  chd_out_if.source  out_o
);

  chd_pkg::res_pair_t push;
  logic               space_ok;

  chd_decode #(
    .LenBits (LENGTH_BITS)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  chd_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

// File: hdl/chd_decode.sv
// Chunk framing state machine: parses size lines, passes payload, builds result beats.
`default_nettype none
module chd_decode #(
  parameter int unsigned LenBits = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  chd_in_if.sink              in_i,
  input  wire                 space_ok_i,
  output chd_pkg::res_pair_t  push_o
);

  chd_pkg::phase_e      phase_q, phase_d, ph_n;
  logic [LenBits-1:0]   acc_q, acc_d, acc_n;
  logic                 de_q, de_d, de_n;
  logic                 pcr_q, pcr_d, pcr_n;
  logic [LenBits-1:0]   rem_q, rem_d, rem_n, rem_dec;
  logic [1:0]           skip_q, skip_d, skip_n, skip_dec;
  logic [LenBits-1:0]   tot_q, tot_d, tot_n;
  logic [31:0]          len32;
  chd_pkg::hex_t        hex;
  logic                 fire;
  logic                 in_size, lf_hit, lead_sp, acc_top_nz;
  chd_pkg::result_t     e0, trunc;
  logic                 e0_v, trunc_v;

  assign fire       = in_i.valid && space_ok_i;
  assign in_i.ready = space_ok_i;
  assign hex        = chd_pkg::hex_value(in_i.in_byte);
  assign in_size    = (phase_q == chd_pkg::PH_LEAD) || (phase_q == chd_pkg::PH_DIGITS);
  assign lf_hit     = pcr_q && (in_i.in_byte == chd_pkg::CHAR_LF);
  assign lead_sp    = (phase_q == chd_pkg::PH_LEAD) && (in_i.in_byte == chd_pkg::CHAR_SP);
  assign acc_top_nz = |acc_q[LenBits-1 -: chd_pkg::HEX_BITS];
  assign rem_dec    = (rem_q != '0) ? rem_q - LenBits'(1) : rem_q;
  assign skip_dec   = (skip_q != 2'd0) ? skip_q - 2'd1 : skip_q;

  always_comb begin : next_state
    ph_n   = phase_q;
    acc_n  = acc_q;
    de_n   = de_q;
    pcr_n  = pcr_q;
    rem_n  = rem_q;
    skip_n = skip_q;
    tot_n  = tot_q;
    case (phase_q)
      chd_pkg::PH_LEAD, chd_pkg::PH_DIGITS: begin
        if (lf_hit) begin
          if (acc_q == '0) begin
            ph_n = chd_pkg::PH_DONE;
          end else begin
            rem_n = acc_q;
            ph_n  = chd_pkg::PH_DATA;
          end
          acc_n = '0;
          de_n  = 1'b0;
          pcr_n = 1'b0;
        end else begin
          pcr_n = (in_i.in_byte == chd_pkg::CHAR_CR);
          if (lead_sp) begin
            ph_n = phase_q;
          end else if (!de_q && hex.ok) begin
            if (acc_top_nz) begin
              ph_n = chd_pkg::PH_DONE;
            end else begin
              acc_n = {acc_q[LenBits-chd_pkg::HEX_BITS-1:0], hex.val};
              ph_n  = chd_pkg::PH_DIGITS;
            end
          end else begin
            de_n = 1'b1;
            ph_n = chd_pkg::PH_DIGITS;
          end
        end
      end
      chd_pkg::PH_DATA: begin
        if (tot_q != '1) tot_n = tot_q + LenBits'(1);
        rem_n = rem_dec;
        if (rem_dec == '0) begin
          ph_n   = chd_pkg::PH_SKIP;
          skip_n = chd_pkg::SKIP_LEN;
        end
      end
      chd_pkg::PH_SKIP: begin
        skip_n = skip_dec;
        if (skip_dec == 2'd0) ph_n = chd_pkg::PH_LEAD;
      end
      default: begin
        ph_n = chd_pkg::PH_DONE;
      end
    endcase

    phase_d = phase_q;
    acc_d   = acc_q;
    de_d    = de_q;
    pcr_d   = pcr_q;
    rem_d   = rem_q;
    skip_d  = skip_q;
    tot_d   = tot_q;
    if (fire) begin
      if (in_i.in_end) begin
        phase_d = chd_pkg::PH_LEAD;
        acc_d   = '0;
        de_d    = 1'b0;
        pcr_d   = 1'b0;
        rem_d   = '0;
        skip_d  = 2'd0;
        tot_d   = '0;
      end else begin
        phase_d = ph_n;
        acc_d   = acc_n;
        de_d    = de_n;
        pcr_d   = pcr_n;
        rem_d   = rem_n;
        skip_d  = skip_n;
        tot_d   = tot_n;
      end
    end
  end

  // Reported length is the running total clipped to 32 bits.
  if (LenBits > 32) begin : g_len_sat
    assign len32 = (|tot_n[LenBits-1:32]) ? 32'hFFFF_FFFF : tot_n[31:0];
  end else begin : g_len_ext
    assign len32 = 32'(tot_n);
  end

  always_comb begin : outputs
    e0_v         = 1'b0;
    e0.data      = 8'h00;
    e0.status    = chd_pkg::ST_BYTE;
    e0.length    = len32;
    e0.last      = 1'b0;
    if (phase_q == chd_pkg::PH_DATA) begin
      e0_v    = 1'b1;
      e0.data = in_i.in_byte;
    end else if (in_size && lf_hit && (acc_q == '0)) begin
      e0_v      = 1'b1;
      e0.status = chd_pkg::ST_COMPLETE;
    end else if (in_size && !lf_hit && !lead_sp && !de_q && hex.ok && acc_top_nz) begin
      e0_v      = 1'b1;
      e0.status = chd_pkg::ST_OVERFLOW;
    end
    trunc_v      = in_i.in_end && (ph_n != chd_pkg::PH_DONE);
    trunc.data   = 8'h00;
    trunc.status = chd_pkg::ST_TRUNC;
    trunc.length = len32;
    trunc.last   = 1'b1;

    push_o.cnt = 2'd0;
    push_o.r0  = trunc;
    push_o.r1  = trunc;
    if (fire) begin
      push_o.cnt = 2'(e0_v) + 2'(trunc_v);
    end
    if (e0_v) begin
      push_o.r0      = e0;
      push_o.r0.last = !trunc_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= chd_pkg::PH_LEAD;
      acc_q   <= '0;
      de_q    <= 1'b0;
      pcr_q   <= 1'b0;
      rem_q   <= '0;
      skip_q  <= 2'd0;
      tot_q   <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      de_q    <= de_d;
      pcr_q   <= pcr_d;
      rem_q   <= rem_d;
      skip_q  <= skip_d;
      tot_q   <= tot_d;
    end
  end

`ifndef ASSERT_OFF
  a_push_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.cnt != 2'd0) |-> (in_i.valid && in_i.ready))
    else $error("result beats pushed without an accepted input beat");
  a_data_has_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == chd_pkg::PH_DATA) |-> (rem_q != '0))
    else $error("payload phase with no bytes remaining");
  a_skip_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == chd_pkg::PH_SKIP) == (skip_q != 2'd0))
    else $error("skip count out of step with phase");
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == chd_pkg::PH_DONE && !(fire && in_i.in_end)) |=>
      (phase_q == chd_pkg::PH_DONE))
    else $error("left done phase without stream end");
`endif

endmodule
`default_nettype wire

// File: hdl/chd_out_fifo.sv
// Four-entry result queue: takes up to two beats per cycle, delivers one per cycle while out_o is ready.
`default_nettype none
module chd_out_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  chd_pkg::res_pair_t  push_i,
  output logic                space_ok_o,
  chd_out_if.source           out_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  chd_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;

  assign pop        = out_o.valid && out_o.ready;
  assign wr_nxt     = wr_q + PtrW'(1);
  // Room for a two-beat push must be there before the input beat is taken.
  assign space_ok_o = cnt_q <= CntW'(Depth - 2);

  assign out_o.valid       = cnt_q != '0;
  assign out_o.out_byte    = mem_q[rd_q].data;
  assign out_o.out_status  = mem_q[rd_q].status;
  assign out_o.body_length = mem_q[rd_q].length;
  assign out_o.out_last    = mem_q[rd_q].last;

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.cnt);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wr_nxt] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overrun");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == PtrW'(cnt_q))
    else $error("queue pointers disagree with fill count");
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> space_ok_o)
    else $error("push into queue without room");
`endif

endmodule
`default_nettype wire

// File: bench/http_chunked_body_decoder_tb.sv
// Self-checking testbench for the HTTP/1.1 chunked body decoder.
`timescale 1ns / 100ps

module http_chunked_body_decoder_tb;

  localparam int unsigned LEN_W = 32;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned BYTES_PER_PROFILE = 360;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } raw_beat_t;

  logic clk_i;
  logic rst_ni;

  chd_in_if  in_bus ();
  chd_out_if out_bus ();

  http_chunked_body_decoder #(
    .LENGTH_BITS(LEN_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Raw stream waiting to be sent, and the results the decoder still owes.
  raw_beat_t         raw_stream[$];
  chd_pkg::result_t  owed_results[$];
  logic [7:0]        body_buf[$];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_go      = 1'b0;
  logic        rx_hold;

  int unsigned errors       = 0;
  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen[4];

  // Decoder state as predicted
  chd_pkg::phase_e  dec_phase;
  logic [LEN_W-1:0] size_acc;
  logic [LEN_W-1:0] chunk_left;
  logic [LEN_W-1:0] decoded_total;
  bit          size_done;
  bit          cr_seen;
  logic [1:0]  skip_left;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] nib);
    logic [7:0] lc;
    lc  = c | 8'h20;
    nib = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) return 1'b1;
    nib = c[3:0] + 4'd9;
    return lc >= 8'h61 && lc <= 8'h66;
  endfunction

  task automatic clear_decoder();
    dec_phase     = chd_pkg::PH_LEAD;
    size_acc      = '0;
    chunk_left    = '0;
    decoded_total = '0;
    size_done     = 1'b0;
    cr_seen       = 1'b0;
    skip_left     = '0;
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic fin);
    chd_pkg::result_t outs[2];
    int unsigned n;
    logic [3:0]  nib;
    bit          is_hex;
    n = 0;
    if (dec_phase == chd_pkg::PH_LEAD || dec_phase == chd_pkg::PH_DIGITS) begin
      if (cr_seen && c == chd_pkg::CHAR_LF) begin
        if (size_acc == '0) begin
          dec_phase = chd_pkg::PH_DONE;
          outs[n] = '{8'h00, chd_pkg::ST_COMPLETE, decoded_total, 1'b0};
          n++;
        end else begin
          chunk_left = size_acc;
          dec_phase  = chd_pkg::PH_DATA;
        end
        size_acc  = '0;
        size_done = 1'b0;
        cr_seen   = 1'b0;
      end else begin
        is_hex  = hex_digit(c, nib);
        cr_seen = (c == chd_pkg::CHAR_CR);
        if (!(dec_phase == chd_pkg::PH_LEAD && c == chd_pkg::CHAR_SP)) begin
          if (!size_done && is_hex) begin
            if (size_acc[LEN_W-1 -: 4] != 4'h0) begin
              dec_phase = chd_pkg::PH_DONE;
              outs[n] = '{8'h00, chd_pkg::ST_OVERFLOW, decoded_total, 1'b0};
              n++;
            end else begin
              size_acc  = {size_acc[LEN_W-5:0], nib};
              dec_phase = chd_pkg::PH_DIGITS;
            end
          end else begin
            size_done = 1'b1;
            dec_phase = chd_pkg::PH_DIGITS;
          end
        end
      end
    end else if (dec_phase == chd_pkg::PH_DATA) begin
      if (decoded_total != '1) decoded_total++;
      outs[n] = '{c, chd_pkg::ST_BYTE, decoded_total, 1'b0};
      n++;
      if (chunk_left != '0) chunk_left--;
      if (chunk_left == '0) begin
        dec_phase = chd_pkg::PH_SKIP;
        skip_left = chd_pkg::SKIP_LEN;
      end
    end else if (dec_phase == chd_pkg::PH_SKIP) begin
      if (skip_left != 2'd0) skip_left--;
      if (skip_left == 2'd0) dec_phase = chd_pkg::PH_LEAD;
    end

    if (fin) begin
      if (dec_phase != chd_pkg::PH_DONE) begin
        outs[n] = '{8'h00, chd_pkg::ST_TRUNC, decoded_total, 1'b0};
        n++;
      end
      clear_decoder();
    end
    if (n != 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) owed_results.push_back(outs[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.in_byte = '0;
    in_bus.in_end  = 1'b0;
    out_bus.ready  = 1'b0;
    clear_decoder();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d results still owed, %0d bytes unsent",
             owed_results.size(), raw_stream.size());
    $display("status: fail");
    $finish;
  end

  // Long output hold-off, counted here while the sender keeps going
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Driver and monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    raw_beat_t nxt;
    if (!rst_ni) begin
      in_bus.valid   <= 1'b0;
      in_bus.in_byte <= '0;
      in_bus.in_end  <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        decode_byte(in_bus.in_byte, in_bus.in_end);
        bytes_sent++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (raw_stream.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = raw_stream.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.in_byte <= nxt.data;
          in_bus.in_end  <= nxt.fin;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h (result %0d)",
               $time, what, got, want, results_seen);
  endtask

  task automatic check_result();
    chd_pkg::result_t want;
    results_seen++;
    if (owed_results.size() == 0) begin
      report_mismatch("unexpected result beat", 32'(out_bus.out_status), 32'h0);
      return;
    end
    want = owed_results.pop_front();
    status_seen[want.status]++;
    if (out_bus.out_byte !== want.data)
      report_mismatch("out_byte", 32'(out_bus.out_byte), 32'(want.data));
    if (out_bus.out_status !== want.status)
      report_mismatch("out_status", 32'(out_bus.out_status), 32'(want.status));
    if (out_bus.body_length !== want.length)
      report_mismatch("body_length", out_bus.body_length, want.length);
    if (out_bus.out_last !== want.last)
      report_mismatch("out_last", 32'(out_bus.out_last), 32'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_result();
      out_bus.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stream builders
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) body_buf.push_back(s[i]);
  endtask

  task automatic push_eol();
    body_buf.push_back(chd_pkg::CHAR_CR);
    body_buf.push_back(chd_pkg::CHAR_LF);
  endtask

  task automatic push_hex(input logic [31:0] v);
    int nd;
    nd = 8;
    while (nd > 1 && v[4*(nd-1) +: 4] == 4'h0) nd--;
    for (int i = nd - 1; i >= 0; i--) body_buf.push_back(hex_char(v[4*i +: 4]));
  endtask

  task automatic push_noise(input int unsigned n);
    repeat (n) body_buf.push_back(8'($urandom));
  endtask

  task automatic commit_msg(input bit with_end);
    raw_beat_t b;
    for (int i = 0; i < body_buf.size(); i++) begin
      b.data = body_buf[i];
      b.fin  = with_end && (i == body_buf.size() - 1);
      raw_stream.push_back(b);
    end
    body_buf.delete();
  endtask

  task automatic put_size_line(input int unsigned v);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) body_buf.push_back(chd_pkg::CHAR_SP);
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) body_buf.push_back(8'h30);
    push_hex(v);
    case ($urandom_range(0, 9))
      0: push_str(";ext=1");
      1: push_str(" ;n");
      2: begin
        // CR not followed by LF must not end the line
        body_buf.push_back(chd_pkg::CHAR_CR);
        body_buf.push_back(8'h7A);
      end
      default: ;
    endcase
    push_eol();
  endtask

  task automatic gen_chunked_body();
    int unsigned nchunks;
    int unsigned clen;
    int unsigned cut;
    nchunks = $urandom_range(1, 4);
    repeat (nchunks) begin
      clen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
      put_size_line(clen);
      push_noise(clen);
      if ($urandom_range(0, 9) == 0) push_noise(2);
      else push_eol();
    end
    put_size_line(0);
    if ($urandom_range(0, 3) == 0) begin
      push_str("X-Trailer: 1");
      push_eol();
    end
    push_eol();
    if ($urandom_range(0, 4) == 0) push_noise($urandom_range(1, 4));
    // some bodies lose their tail
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(0, body_buf.size() - 1);
      while (body_buf.size() > cut + 1) void'(body_buf.pop_back());
    end
    commit_msg(1'b1);
  endtask

  task automatic gen_message();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      gen_chunked_body();
    end else if (pick < 73) begin
      push_noise($urandom_range(1, 12));
      commit_msg(1'b1);
    end else if (pick < 80) begin
      // nine or more significant digits
      if ($urandom_range(0, 1)) body_buf.push_back(8'h30);
      body_buf.push_back(hex_char(4'($urandom_range(1, 15))));
      repeat ($urandom_range(8, 10)) body_buf.push_back(hex_char(4'($urandom)));
      push_eol();
      commit_msg(1'b1);
    end else if (pick < 86) begin
      push_hex({4'($urandom_range(1, 15)), 28'($urandom)});
      push_eol();
      push_noise($urandom_range(1, 6));
      commit_msg(1'b1);
    end else begin
      // sign or 0x prefix ends the number
      n = $urandom_range(0, 3);
      if (n != 0) push_hex(n);
      case ($urandom_range(0, 3))
        0: push_str("-");
        1: push_str("+");
        2: push_str("0x");
        default: push_str("0X");
      endcase
      repeat ($urandom_range(1, 3)) body_buf.push_back(hex_char(4'($urandom)));
      push_eol();
      if (n != 0) begin
        push_noise(n);
        push_eol();
        put_size_line(0);
        push_eol();
      end
      commit_msg(1'b1);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (raw_stream.size() != 0 || in_bus.valid || owed_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    // one-byte chunk of 0xFF, left open
    push_str("1");
    push_eol();
    body_buf.push_back(8'hFF);
    push_eol();
    commit_msg(1'b0);
    // stray CR in the size line, then the stream ends mid-chunk
    push_str("3");
    body_buf.push_back(chd_pkg::CHAR_CR);
    push_eol();
    body_buf.push_back(8'h00);
    body_buf.push_back(8'h61);
    commit_msg(1'b1);
    // leading space and 0x prefix read as size zero; end after completion
    push_str(" 0x5");
    push_eol();
    body_buf.push_back(8'hFF);
    commit_msg(1'b1);
    // size overflow on the ninth digit
    push_str("123456789");
    commit_msg(1'b1);
    wait_drained();

    for (int prof = 0; prof < 5; prof++) begin
      case (prof)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        3: begin tx_idle_pct = 29; rx_stall_pct = 29; end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          hold_go      = 1'b1;
        end
      endcase
      while (raw_stream.size() < BYTES_PER_PROFILE) gen_message();
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("run covered %0d raw bytes: directed cases, four idle profiles and a %0d-cycle hold",
             bytes_sent, HOLD_CYCLES);
    $display("result beats: %0d payload, %0d complete, %0d truncated, %0d overflow",
             status_seen[chd_pkg::ST_BYTE], status_seen[chd_pkg::ST_COMPLETE],
             status_seen[chd_pkg::ST_TRUNC], status_seen[chd_pkg::ST_OVERFLOW]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
